### design/itr_pkg.sv
// shared types, symbol codes and digit pattern helpers for the roman numeral encoder
`default_nettype none
package itr_pkg;

  localparam int unsigned NUM_W  = 12;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned NDIG   = 4;
  localparam int unsigned SYM_W  = 7;

  localparam logic [NUM_W-1:0] MAX_VALID = 12'd3999;

  localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
  localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
  localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
  localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
  localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
  localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
  localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
  localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;

  typedef logic [DIG_W-1:0] digit_t;

  // dig[3] thousands down to dig[0] units
  typedef struct packed {
    logic                  err;
    logic [NDIG-1:0][DIG_W-1:0] dig;
  } itr_digits_t;

  function automatic logic [SYM_W-1:0] sym_one(input logic [1:0] pos);
    logic [SYM_W-1:0] s;
    unique case (pos)
      2'd0: s = SYM_I;
      2'd1: s = SYM_X;
      2'd2: s = SYM_C;
      default: s = SYM_M;
    endcase
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] sym_five(input logic [1:0] pos);
    logic [SYM_W-1:0] s;
    unique case (pos)
      2'd0: s = SYM_V;
      2'd1: s = SYM_L;
      2'd2: s = SYM_D;
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [SYM_W-1:0] sym_ten(input logic [1:0] pos);
    logic [SYM_W-1:0] s;
    unique case (pos)
      2'd0: s = SYM_X;
      2'd1: s = SYM_C;
      2'd2: s = SYM_M;
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

  // number of symbols one decimal digit produces
  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] n;
    unique case (d) inside
      4'd0:                   n = 3'd0;
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  // k-th symbol of the pattern for digit d at position pos
  function automatic logic [SYM_W-1:0] digit_sym(input digit_t d, input logic [1:0] pos,
                                                 input logic [1:0] k);
    logic [SYM_W-1:0] s;
    unique case (d) inside
      4'd1, 4'd2, 4'd3:       s = sym_one(pos);
      4'd4:                   s = (k == 2'd0) ? sym_one(pos) : sym_five(pos);
      4'd5, 4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? sym_five(pos) : sym_one(pos);
      4'd9:                   s = (k == 2'd0) ? sym_one(pos) : sym_ten(pos);
      default:                s = SYM_NONE;
    endcase
    return s;
  endfunction

  // highest set position of a four-bit mask
  function automatic logic [1:0] hi_pos(input logic [NDIG-1:0] m);
    logic [1:0] p;
    if (m[3]) begin
      p = 2'd3;
    end else if (m[2]) begin
      p = 2'd2;
    end else if (m[1]) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### design/itr_digit_split.sv
// four stage pipeline that range checks a number and splits it into decimal digits
`default_nettype none
module itr_digit_split
  import itr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [NUM_W-1:0] in_number,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output itr_digits_t           out_digits
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  logic [NUM_W-1:0] num1_r;
  logic             err1_r, err2_r, err3_r;
  logic [9:0]       rem2_r;
  digit_t           th2_r, th3_r, hd3_r;
  logic [6:0]       rem3_r;
  itr_digits_t      dig4_r;

  digit_t           th_nxt, hd_nxt, tn_nxt, un_nxt;
  logic [9:0]       rem2_nxt;
  logic [6:0]       rem3_nxt;

  // a stage moves when it is empty or the stage after it moves
  assign adv4 = !v4_r || out_ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // thousands by compare against the three multiples
  always_comb begin
    if (num1_r >= 12'd3000) begin
      th_nxt = 4'd3;
    end else if (num1_r >= 12'd2000) begin
      th_nxt = 4'd2;
    end else if (num1_r >= 12'd1000) begin
      th_nxt = 4'd1;
    end else begin
      th_nxt = 4'd0;
    end
    rem2_nxt = 10'(num1_r - 12'(th_nxt) * 12'd1000);
  end

  // hundreds: count thresholds passed
  always_comb begin
    hd_nxt = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      hd_nxt = hd_nxt + 4'(rem2_r >= 10'(i * 100));
    end
    rem3_nxt = 7'(rem2_r - 10'(hd_nxt) * 10'd100);
  end

  always_comb begin
    tn_nxt = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      tn_nxt = tn_nxt + 4'(rem3_r >= 7'(i * 10));
    end
    un_nxt = 4'(rem3_r - 7'(tn_nxt) * 7'd10);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      num1_r <= in_number;
      err1_r <= (in_number == '0) || (in_number > MAX_VALID);
    end
    if (adv2) begin
      th2_r  <= th_nxt;
      rem2_r <= rem2_nxt;
      err2_r <= err1_r;
    end
    if (adv3) begin
      th3_r  <= th2_r;
      hd3_r  <= hd_nxt;
      rem3_r <= rem3_nxt;
      err3_r <= err2_r;
    end
    if (adv4) begin
      dig4_r.err    <= err3_r;
      dig4_r.dig[3] <= th3_r;
      dig4_r.dig[2] <= hd3_r;
      dig4_r.dig[1] <= tn_nxt;
      dig4_r.dig[0] <= un_nxt;
    end
  end

  assign out_valid  = v4_r;
  assign out_digits = dig4_r;

endmodule
`default_nettype wire

### design/integer_to_roman_encoder.sv
// top level: digit split pipeline followed by the symbol serializer
`default_nettype none
// Converts a 12-bit unsigned number to its Roman numeral, sent as one ASCII
// symbol per output beat, most significant first, with tlast on the final
// symbol. Numbers 0 and 4000..4095 give a single beat with symbol 0, tlast
// and the range_error flag set. A number passes through the four-stage digit
// split pipeline into the serializer, which sends its symbols (1 to 15, one
// for an error) one per beat, so the sustained rate is one output symbol per
// cycle while out_tready is high and numbers keep arriving. The pipeline keeps
// taking numbers while the serializer drains the current one, until it is full.
module integer_to_roman_encoder
  import itr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] number, [15:12] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [6:0] symbol, [7] zero
  output logic             out_tlast,
  output logic             out_tuser   // [0] range_error
);

  logic        sp_valid;
  logic        sp_ready;
  itr_digits_t sp_digits;

  itr_digit_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_number  (in_tdata[NUM_W-1:0]),
    .out_valid  (sp_valid),
    .out_ready  (sp_ready),
    .out_digits (sp_digits)
  );

  // serializer state
  logic                       busy_r, busy_nxt;
  logic                       err_r, err_nxt;
  logic [NDIG-1:0][DIG_W-1:0] dig_r, dig_nxt;
  logic [NDIG-1:0]            nz_r, nz_nxt;
  logic [1:0]                 pos_r, pos_nxt;
  logic [1:0]                 k_r, k_nxt;

  logic            fire;
  logic            end_digit;
  logic            is_last;
  logic [NDIG-1:0] lower;
  logic [NDIG-1:0] in_nz;
  logic [2:0]      cur_len;

  assign cur_len   = digit_len(dig_r[pos_r]);
  assign end_digit = ({1'b0, k_r} == cur_len - 3'd1);
  assign lower     = nz_r & NDIG'((4'd1 << pos_r) - 4'd1);
  assign is_last   = err_r || (end_digit && (lower == '0));
  assign fire      = busy_r && out_tready;
  assign sp_ready  = !busy_r || (fire && is_last);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      in_nz[i] = (sp_digits.dig[i] != '0);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    err_nxt  = err_r;
    dig_nxt  = dig_r;
    nz_nxt   = nz_r;
    pos_nxt  = pos_r;
    k_nxt    = k_r;
    if (sp_ready) begin
      busy_nxt = sp_valid;
      err_nxt  = sp_digits.err;
      dig_nxt  = sp_digits.dig;
      nz_nxt   = in_nz;
      pos_nxt  = hi_pos(in_nz);
      k_nxt    = 2'd0;
    end else if (fire) begin
      if (end_digit) begin
        pos_nxt = hi_pos(lower);
        k_nxt   = 2'd0;
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    dig_r <= dig_nxt;
    nz_r  <= nz_nxt;
    pos_r <= pos_nxt;
    k_r   <= k_nxt;
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = err_r ? 8'd0 : {1'b0, digit_sym(dig_r[pos_r], pos_r, k_r)};
  assign out_tlast  = is_last;
  assign out_tuser  = err_r;

  a_err_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 8'd0))
    else $error("error beat not a single zero symbol");

  a_sym_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata != 8'd0))
    else $error("valid numeral beat carries no symbol");

  a_k_in_digit : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !err_r |-> ({1'b0, k_r} < cur_len))
    else $error("symbol index beyond digit pattern");

  a_load_on_done : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !(out_tready && is_last) |-> !sp_ready)
    else $error("serializer reloaded before numeral finished");

endmodule
`default_nettype wire
